/* rtl/pid_ds_pkg.sv */
`default_nettype none
package pid_ds_pkg;

  // Field and register widths
  localparam int MEAS_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int DB_W       = 15;
  localparam int SEP_W      = 17;
  localparam int ILIM_W     = 23;
  localparam int ERR_W      = 18;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int INT_W      = 24;
  localparam int DRIVE_W    = 32;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  // Gains are signed fixed point with this many fraction bits
  localparam int GAIN_FRAC_BITS = 8;

  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + INT_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int ACC_W    = PROD_I_W + 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [SEP_W-1:0]  SEP_LIMIT_RST = '1;
  localparam logic [ILIM_W-1:0] INT_LIMIT_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET        = 3'd0,
    CFG_TARGET_OFFSET = 3'd1,
    CFG_KP            = 3'd2,
    CFG_KI            = 3'd3,
    CFG_KD            = 3'd4,
    CFG_DEAD_BAND     = 3'd5,
    CFG_SEP_LIMIT     = 3'd6,
    CFG_INT_LIMIT     = 3'd7
  } cfg_idx_t;

endpackage
`default_nettype wire

/* rtl/pid_deadband_int_separation_top.sv */
`default_nettype none
// Channel | Direction | tdata fields (low bit up)              | tuser / tlast
// in_     | slave     | measured_value[15:0]                    | none
// out_    | master    | drive[31:0], drive_saturated, pad[6:0]  | none
// cfg_    | write     | cfg_index selects register, cfg_wdata   | none
//
// Single pass: the input register holds the sample; error, dead band, integral
// update, three products, floor shift and saturation settle combinationally
// into the result register when it is free, one item per cycle sustained;
// the input stalls only while a result waits on out_tready. Reset (rst_n
// low, synchronous) empties both registers and restores registers and state.
module pid_deadband_int_separation_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pid_ds_pkg::IN_TDATA_W-1:0] in_tdata,   // measured_value[15:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // drive[31:0], drive_saturated[32], zero[39:33]
  output logic [pid_ds_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pid_ds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pid_ds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pid_ds_pkg::*;

  // Configuration registers
  logic signed [GAIN_W-1:0] target_r, target_offset_r, kp_r, ki_r, kd_r;
  logic [DB_W-1:0]          dead_band_r;
  logic [SEP_W-1:0]         sep_limit_r;
  logic [ILIM_W-1:0]        int_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r        <= '0;
      target_offset_r <= '0;
      kp_r            <= '0;
      ki_r            <= '0;
      kd_r            <= '0;
      dead_band_r     <= '0;
      sep_limit_r     <= SEP_LIMIT_RST;
      int_limit_r     <= INT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET:        target_r        <= cfg_wdata[GAIN_W-1:0];
        CFG_TARGET_OFFSET: target_offset_r <= cfg_wdata[GAIN_W-1:0];
        CFG_KP:            kp_r            <= cfg_wdata[GAIN_W-1:0];
        CFG_KI:            ki_r            <= cfg_wdata[GAIN_W-1:0];
        CFG_KD:            kd_r            <= cfg_wdata[GAIN_W-1:0];
        CFG_DEAD_BAND:     dead_band_r     <= cfg_wdata[DB_W-1:0];
        CFG_SEP_LIMIT:     sep_limit_r     <= cfg_wdata[SEP_W-1:0];
        CFG_INT_LIMIT:     int_limit_r     <= cfg_wdata[ILIM_W-1:0];
      endcase
    end
  end

  // Valids and flow control
  logic in_valid_r, out_valid_r;
  logic out_free, advance;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;
  assign advance   = in_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r  <= in_tvalid;
      if (out_free)  out_valid_r <= in_valid_r;
    end
  end

  // Input register
  logic [MEAS_W-1:0] meas_r;

  always_ff @(posedge clk) begin
    if (in_tready) meas_r <= in_tdata[MEAS_W-1:0];
  end

  // Error, dead band, integral separation and clamp, derivative difference
  logic signed [MEAS_W-1:0] meas;
  logic signed [ERR_W-1:0]  err_raw, err_db;
  logic signed [DIFF_W-1:0] err_ext, err_db_ext, db_s, sep_s;
  logic                     in_band, integrate;
  logic signed [INT_W:0]    isum, lim_s, iclamp;
  logic signed [INT_W-1:0]  integ_nxt, integral_sum_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    meas       = $signed(meas_r);
    err_raw    = ERR_W'(target_r) + ERR_W'(target_offset_r) - ERR_W'(meas);
    err_ext    = DIFF_W'(err_raw);
    db_s       = $signed({{(DIFF_W-DB_W){1'b0}}, dead_band_r});
    in_band    = (err_ext >= -db_s) && (err_ext <= db_s);
    err_db     = in_band ? '0 : err_raw;
    err_db_ext = DIFF_W'(err_db);
    sep_s      = $signed({{(DIFF_W-SEP_W){1'b0}}, sep_limit_r});
    integrate  = (err_db_ext > -sep_s) && (err_db_ext < sep_s);

    isum  = (INT_W+1)'(integral_sum_r) + (INT_W+1)'(err_db);
    lim_s = $signed({{(INT_W+1-ILIM_W){1'b0}}, int_limit_r});
    priority if (isum > lim_s)  iclamp = lim_s;
    else if (isum < -lim_s)     iclamp = -lim_s;
    else                        iclamp = isum;
    integ_nxt = integrate ? iclamp[INT_W-1:0] : integral_sum_r;

    diff = err_db_ext - DIFF_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_sum_r <= '0;
      prev_err_r     <= '0;
    end else if (advance) begin
      integral_sum_r <= integ_nxt;
      prev_err_r     <= err_db;
    end
  end

  // Gain products, sum, floor shift, saturate
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [ACC_W-1:0]    acc, acc_sh;
  logic [ACC_W-DRIVE_W:0]     hi_bits;
  logic                       sat_nxt;
  logic [DRIVE_W-1:0]         drive_nxt, drive_r;
  logic                       sat_r;

  always_comb begin
    prod_p  = PROD_P_W'(kp_r) * PROD_P_W'(err_db);
    prod_i  = PROD_I_W'(ki_r) * PROD_I_W'(integ_nxt);
    prod_d  = PROD_D_W'(kd_r) * PROD_D_W'(diff);
    acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    acc_sh  = acc >>> GAIN_FRAC_BITS;
    hi_bits = acc_sh[ACC_W-1:DRIVE_W-1];
    sat_nxt = !((&hi_bits) || !(|hi_bits));
    if (sat_nxt) begin
      drive_nxt = acc_sh[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                  : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      drive_nxt = acc_sh[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DRIVE_W-1){1'b0}}, sat_r, drive_r};

endmodule
`default_nettype wire
